[rtl/rotation_matrix_to_quaternion_macros.svh]
// assertion macros for the rotation matrix to quaternion block
// no dependencies; included by modules that carry concurrent checks
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RMQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rmq_pkg.sv]
// shared constants and the pipeline item type for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int IW        = 16;               // matrix and quaternion field width
  localparam int VW        = IW + 2;           // scaled vector component, signed
  localparam int MW        = VW - 1;           // magnitude of a component
  localparam int SQW       = 2 * MW;           // one square
  localparam int SW        = SQW + 2;          // sum of four squares
  localparam int RW        = SW / 2;           // integer square root
  localparam int NW        = MW + FRAC_BITS + 3; // division numerator
  localparam int QW        = FRAC_BITS + 1;    // quotient bits, q never exceeds ONE

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef struct packed {
    logic [1:0]           branch;
    logic                 deg;
    logic [3:0]           neg;
    logic [3:0][MW-1:0]   mag;
  } item_t;

endpackage

[rtl/rotation_matrix_to_quaternion.sv]
// top level: rotation matrix (three basis columns) to unit quaternion, Shepperd's method
// depends on rmq_pkg, rmq_front, rmq_isqrt, rmq_div and the assertion macro header
//
//  channel   | dir | payload                                   | handshake
//  ----------+-----+-------------------------------------------+-------------------
//  s_ (in)   | in  | tdata: nine Q2.14 matrix elements         | s_tvalid/s_tready
//  m_ (out)  | out | tdata: w x y z Q2.14; tuser: branch, flag | m_tvalid/m_tready
//
// one transfer in per cycle while the output is not stalled; from input to output register
// a transfer passes three front stages, nine square root stages (two root bits each), five
// division stages (three quotient bits each) and the output register
// rst is synchronous; it clears the valid bits only, payload registers are not reset
// a stall on the output freezes the whole pipeline through one clock enable, which is
// also s_tready; when the output register is empty the pipeline keeps moving
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // right_x, right_y, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z (16 bits each)
  input  logic [143:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic [63:0]   m_tdata,
  // pivot_branch [1:0], degenerate [2]
  output logic [2:0]    m_tuser
);

  logic                 ce;
  logic signed [IW-1:0] mat [9];

  logic                 f_valid;
  item_t                f_item;
  logic [SW-1:0]        f_sum;

  logic                 r_valid;
  item_t                r_item;
  logic [RW-1:0]        r_root;

  logic signed [IW-1:0] quat [4];
  logic [1:0]           branch;
  logic                 deg;

  // pipeline advances unless a result is held on the output
  assign ce       = m_tready | ~m_tvalid;
  assign s_tready = ce;

  always_comb begin
    for (int i = 0; i < 9; i++) mat[i] = s_tdata[i*IW +: IW];
  end

  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .m         (mat),
    .out_valid (f_valid),
    .out_item  (f_item),
    .out_sum   (f_sum)
  );

  rmq_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .in_sum    (f_sum),
    .out_valid (r_valid),
    .out_item  (r_item),
    .out_root  (r_root)
  );

  rmq_div u_div (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (r_valid),
    .in_item    (r_item),
    .in_root    (r_root),
    .out_valid  (m_tvalid),
    .out_quat   (quat),
    .out_branch (branch),
    .out_deg    (deg)
  );

  assign m_tdata = {quat[3], quat[2], quat[1], quat[0]};
  assign m_tuser = {deg, branch};

  // a zero-length result carries an all-zero quaternion
  `RMQ_ASSERT_SAME(a_deg_zero, m_tvalid && deg, m_tdata == 64'd0, "degenerate with nonzero data")
  // every component stays within plus or minus one
  `RMQ_ASSERT_SAME(a_quat_range, m_tvalid, (quat[0] <= IW'(ONE)) && (quat[0] >= -IW'(ONE)) && (quat[1] <= IW'(ONE)) && (quat[1] >= -IW'(ONE)) && (quat[2] <= IW'(ONE)) && (quat[2] >= -IW'(ONE)) && (quat[3] <= IW'(ONE)) && (quat[3] >= -IW'(ONE)), "quaternion component out of range")
  // a held result blocks new input
  `RMQ_ASSERT_SAME(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "input taken during output stall")

endmodule

[rtl/rmq_front.sv]
// branch select, scaled vector, squares and their sum (three stages)
// depends on rmq_pkg
module rmq_front import rmq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic                  in_valid,
  input  logic signed [IW-1:0]  m [9],
  output logic                  out_valid,
  output item_t                 out_item,
  output logic [SW-1:0]         out_sum
);

  // m order: m00 m10 m20 m01 m11 m21 m02 m12 m22
  logic signed [VW-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22, t, one_v;
  logic signed [VW-1:0] v_next [4];
  logic [1:0]           br_next;

  logic                 vld1, vld2;
  logic signed [VW-1:0] v1 [4];
  logic [MW-1:0]        mag1 [4];
  logic [1:0]           br1, br2;
  logic [3:0]           neg2;
  logic [3:0][MW-1:0]   mag2;
  logic [SQW-1:0]       sq2 [4];

  always_comb begin
    m00 = VW'(m[0]); m10 = VW'(m[1]); m20 = VW'(m[2]);
    m01 = VW'(m[3]); m11 = VW'(m[4]); m21 = VW'(m[5]);
    m02 = VW'(m[6]); m12 = VW'(m[7]); m22 = VW'(m[8]);
    one_v = VW'(ONE);
    t = m00 + m11 + m22;
    if (t > 0) begin
      br_next = BR_TRACE;
      v_next[0] = one_v + t;
      v_next[1] = m21 - m12;
      v_next[2] = m02 - m20;
      v_next[3] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      br_next = BR_X;
      v_next[0] = m21 - m12;
      v_next[1] = one_v + m00 - m11 - m22;
      v_next[2] = m01 + m10;
      v_next[3] = m02 + m20;
    end else if (m11 > m22) begin
      br_next = BR_Y;
      v_next[0] = m02 - m20;
      v_next[1] = m01 + m10;
      v_next[2] = one_v + m11 - m00 - m22;
      v_next[3] = m12 + m21;
    end else begin
      br_next = BR_Z;
      v_next[0] = m10 - m01;
      v_next[1] = m02 + m20;
      v_next[2] = m12 + m21;
      v_next[3] = one_v + m22 - m00 - m11;
    end
    // pivot term clamped at zero
    if (v_next[br_next] < 0) begin
      v_next[br_next] = '0;
    end
  end

  // magnitudes of the registered vector, squared in the same stage
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag1[i] = v1[i][VW-1] ? MW'(-v1[i]) : MW'(v1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        v1[i]   <= v_next[i];
        neg2[i] <= v1[i][VW-1];
        mag2[i] <= mag1[i];
        sq2[i]  <= SQW'(mag1[i]) * SQW'(mag1[i]);
      end
      br1 <= br_next;
      br2 <= br1;
      out_item.branch <= br2;
      out_item.neg    <= neg2;
      out_item.mag    <= mag2;
      out_sum         <= SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]) + SW'(sq2[3]);
      out_item.deg    <= (sq2[0] | sq2[1] | sq2[2] | sq2[3]) == '0;
    end
  end

endmodule

[rtl/rmq_isqrt.sv]
// pipelined integer square root, two root bits per stage
// depends on rmq_pkg
module rmq_isqrt import rmq_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           ce,
  input  logic           in_valid,
  input  item_t          in_item,
  input  logic [SW-1:0]  in_sum,
  output logic           out_valid,
  output item_t          out_item,
  output logic [RW-1:0]  out_root
);

  localparam int NSTG = RW / 2;
  localparam int REMW = RW + 2;

  logic              vld  [NSTG];
  item_t             itm  [NSTG];
  logic [SW-1:0]     rad  [NSTG];
  logic [REMW-1:0]   rem  [NSTG];
  logic [RW-1:0]     root [NSTG];

  logic [SW-1:0]     rad_next  [NSTG];
  logic [REMW-1:0]   rem_next  [NSTG];
  logic [RW-1:0]     root_next [NSTG];

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin : stg
      logic [REMW-1:0] r;
      logic [RW-1:0]   q;
      logic [SW-1:0]   x;
      logic [REMW+1:0] acc;
      logic [REMW+1:0] trial;
      if (k == 0) begin
        r = '0;
        q = '0;
        x = in_sum;
      end else begin
        r = rem[k-1];
        q = root[k-1];
        x = rad[k-1];
      end
      for (int j = 0; j < 2; j++) begin
        acc   = {r, x[SW-1 -: 2]};
        trial = {2'b00, q, 2'b01};
        if (acc >= trial) begin
          acc = acc - trial;
          q   = {q[RW-2:0], 1'b1};
        end else begin
          q   = {q[RW-2:0], 1'b0};
        end
        r = acc[REMW-1:0];
        x = {x[SW-3:0], 2'b00};
      end
      rem_next[k]  = r;
      root_next[k] = q;
      rad_next[k]  = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) vld[k] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      itm[0] <= in_item;
      for (int k = 1; k < NSTG; k++) itm[k] <= itm[k-1];
      for (int k = 0; k < NSTG; k++) begin
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
        rad[k]  <= rad_next[k];
      end
    end
  end

  assign out_valid = vld[NSTG-1];
  assign out_item  = itm[NSTG-1];
  assign out_root  = root[NSTG-1];

endmodule

[rtl/rmq_div.sv]
// pipelined rounding division of each magnitude by the length, three bits per stage,
// then sign, zero forcing and saturation; depends on rmq_pkg
module rmq_div import rmq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic                  in_valid,
  input  item_t                 in_item,
  input  logic [RW-1:0]         in_root,
  output logic                  out_valid,
  output logic signed [IW-1:0]  out_quat [4],
  output logic [1:0]            out_branch,
  output logic                  out_deg
);

  localparam int DSTG = (QW + 2) / 3;

  logic              vld [DSTG];
  item_t             itm [DSTG];
  logic [NW-1:0]     den [DSTG];
  logic [NW-1:0]     rem [DSTG][4];
  logic [QW-1:0]     quo [DSTG][4];

  logic [NW-1:0]     den_next [DSTG];
  logic [NW-1:0]     rem_next [DSTG][4];
  logic [QW-1:0]     quo_next [DSTG][4];

  // q = floor((2*mag*ONE + len) / (2*len)), restoring, msb first
  always_comb begin
    for (int k = 0; k < DSTG; k++) begin : stg
      logic [NW-1:0] d;
      logic [NW-1:0] r;
      logic [QW-1:0] q;
      logic [NW-1:0] ds;
      int            b;
      if (k == 0) begin
        d = NW'({in_root, 1'b0});
      end else begin
        d = den[k-1];
      end
      den_next[k] = d;
      for (int i = 0; i < 4; i++) begin
        if (k == 0) begin
          r = (NW'(in_item.mag[i]) << (FRAC_BITS + 1)) + NW'(in_root);
          q = '0;
        end else begin
          r = rem[k-1][i];
          q = quo[k-1][i];
        end
        for (int j = 0; j < 3; j++) begin
          b = QW - 1 - (3 * k + j);
          if (b >= 0) begin
            ds = d << b;
            if (r >= ds) begin
              r    = r - ds;
              q[b] = 1'b1;
            end
          end
        end
        rem_next[k][i] = r;
        quo_next[k][i] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DSTG; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DSTG; k++) vld[k] <= vld[k-1];
      out_valid <= vld[DSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0] qs;
    if (ce) begin
      itm[0] <= in_item;
      for (int k = 1; k < DSTG; k++) itm[k] <= itm[k-1];
      for (int k = 0; k < DSTG; k++) begin
        den[k] <= den_next[k];
        for (int i = 0; i < 4; i++) begin
          rem[k][i] <= rem_next[k][i];
          quo[k][i] <= quo_next[k][i];
        end
      end
      for (int i = 0; i < 4; i++) begin
        qs = (quo[DSTG-1][i] > QW'(ONE)) ? QW'(ONE) : quo[DSTG-1][i];
        if (itm[DSTG-1].deg) begin
          out_quat[i] <= '0;
        end else if (itm[DSTG-1].neg[i]) begin
          out_quat[i] <= -IW'(qs);
        end else begin
          out_quat[i] <= IW'(qs);
        end
      end
      out_branch <= itm[DSTG-1].branch;
      out_deg    <= itm[DSTG-1].deg;
    end
  end

endmodule
